>>> hw/rtl/lzwc_pkg.sv
// shared types and constants of the lzw byte compressor
package lzwc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OUT_CODE_W = 16;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam int unsigned FIRST_NEW_CODE = 256;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic [OUT_CODE_W-1:0] code;
    logic                  end_of_stream;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CMP,
    ST_EMIT_MISS,
    ST_EMIT_LAST
  } state_t;

  typedef struct packed {
    logic take_in;
    logic set_first;
    logic hash;
    logic probe;
    logic step;
    logic hit_take;
    logic insert;
    logic emit_miss;
    logic emit_last;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic has_prefix;
    logic last;
    logic hit;
    logic empty;
    logic probe_end;
    logic clear_end;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/lzwc_ctrl.sv
// controller state machine of the lzw byte compressor
module lzwc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  lzwc_pkg::sts_t sts,
  output lzwc_pkg::cmd_t cmd,
  output logic           in_ready
);

  lzwc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzwc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      lzwc_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_end) state_next = lzwc_pkg::ST_IDLE;
      end
      lzwc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.take_in = 1'b1;
          if (!sts.has_prefix) begin
            cmd.set_first = 1'b1;
            state_next = sts.in_last ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
          end else begin
            state_next = lzwc_pkg::ST_HASH;
          end
        end
      end
      lzwc_pkg::ST_HASH: begin
        cmd.hash = 1'b1;
        state_next = lzwc_pkg::ST_PROBE;
      end
      lzwc_pkg::ST_PROBE: begin
        cmd.probe = 1'b1;
        state_next = lzwc_pkg::ST_CMP;
      end
      lzwc_pkg::ST_CMP: begin
        if (sts.hit) begin
          cmd.hit_take = 1'b1;
          state_next = sts.last ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
        end else if (sts.empty) begin
          cmd.insert = 1'b1;
          state_next = lzwc_pkg::ST_EMIT_MISS;
        end else if (sts.probe_end) begin
          state_next = lzwc_pkg::ST_EMIT_MISS;
        end else begin
          cmd.step = 1'b1;
          state_next = lzwc_pkg::ST_PROBE;
        end
      end
      lzwc_pkg::ST_EMIT_MISS: begin
        if (sts.out_free) begin
          cmd.emit_miss = 1'b1;
          state_next = sts.last ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
        end
      end
      lzwc_pkg::ST_EMIT_LAST: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_next = lzwc_pkg::ST_CLEAR;
        end
      end
      default: state_next = lzwc_pkg::ST_CLEAR;
    endcase
  end

endmodule

>>> hw/rtl/lzwc_dp.sv
// datapath of the lzw byte compressor: string registers, hashed pair table, output register
module lzwc_dp #(
  parameter int unsigned CODE_BITS = 16,
  parameter int unsigned TABLE_ENTRIES = 131072
) (
  input  logic           clk,
  input  logic           rst,
  input  lzwc_pkg::cmd_t cmd,
  output lzwc_pkg::sts_t sts,
  input  logic           in_valid,
  input  lzwc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lzwc_pkg::out_t out_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned ENTRY_W = 1 + 2 * CODE_BITS + lzwc_pkg::BYTE_W;
  localparam logic [CODE_BITS-1:0] CODE_LIMIT = {CODE_BITS{1'b1}};
  localparam logic [IDX_W:0] LAST_IDX = (IDX_W+1)'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic                          valid;
    logic [CODE_BITS-1:0]          prefix;
    logic [lzwc_pkg::BYTE_W-1:0]   byte_val;
    logic [CODE_BITS-1:0]          code;
  } entry_t;

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

  logic [lzwc_pkg::BYTE_W-1:0] byte_r;
  logic                        last_r;
  logic [CODE_BITS-1:0]        cur;
  logic                        has_prefix;
  logic [CODE_BITS-1:0]        next_code;
  logic [IDX_W-1:0]            slot;
  logic [IDX_W:0]              probe_cnt;
  logic [IDX_W:0]              clr_cnt;
  entry_t                      rdata;

  logic [31:0]      key32;
  logic [IDX_W-1:0] hash_idx;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [CODE_BITS-1:0] in_byte_code;
  logic [CODE_BITS-1:0] byte_code;

  assign key32 = 32'({cur, byte_r});
  // low index bits of the product depend only on low bits of both operands
  assign hash_idx = key32[IDX_W-1:0] * lzwc_pkg::HASH_MULT[IDX_W-1:0];
  assign in_byte_code = CODE_BITS'(in_data.data_byte);
  assign byte_code = CODE_BITS'(byte_r);

  always_comb begin
    we = 1'b0;
    waddr = slot;
    wdata = '0;
    if (cmd.clear_step) begin
      we = 1'b1;
      waddr = clr_cnt[IDX_W-1:0];
    end else if (cmd.insert && next_code < CODE_LIMIT) begin
      we = 1'b1;
      wdata.valid = 1'b1;
      wdata.prefix = cur;
      wdata.byte_val = byte_r;
      wdata.code = next_code;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.probe) rdata <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      byte_r <= in_data.data_byte;
      last_r <= in_data.last_byte;
    end
    if (cmd.hash) slot <= hash_idx;
    else if (cmd.step) slot <= slot + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      has_prefix <= 1'b0;
      next_code <= CODE_BITS'(lzwc_pkg::FIRST_NEW_CODE);
      probe_cnt <= '0;
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.set_first) begin
        cur <= in_byte_code;
        has_prefix <= 1'b1;
      end
      if (cmd.hash) probe_cnt <= '0;
      else if (cmd.step) probe_cnt <= probe_cnt + 1'b1;
      if (cmd.hit_take) cur <= rdata.code;
      if (cmd.insert && next_code < CODE_LIMIT) next_code <= next_code + 1'b1;
      if (cmd.emit_miss) begin
        out_valid <= 1'b1;
        out_data.code <= lzwc_pkg::OUT_CODE_W'(cur);
        out_data.end_of_stream <= 1'b0;
        cur <= byte_code;
      end
      if (cmd.emit_last) begin
        out_valid <= 1'b1;
        out_data.code <= lzwc_pkg::OUT_CODE_W'(cur);
        out_data.end_of_stream <= 1'b1;
        cur <= '0;
        has_prefix <= 1'b0;
        next_code <= CODE_BITS'(lzwc_pkg::FIRST_NEW_CODE);
        clr_cnt <= '0;
      end
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    sts.in_valid = in_valid;
    sts.in_last = in_data.last_byte;
    sts.has_prefix = has_prefix;
    sts.last = last_r;
    sts.hit = rdata.valid && (rdata.prefix == cur) && (rdata.byte_val == byte_r);
    sts.empty = !rdata.valid;
    sts.probe_end = (probe_cnt == LAST_IDX);
    sts.clear_end = (clr_cnt == LAST_IDX);
    sts.out_free = !out_valid || out_ready;
  end

endmodule

>>> hw/rtl/lzw_byte_compressor.sv
// top level of the lzw byte compressor with fixed 16-bit output codes
//
// channel  signals                     payload
// input    in_valid / in_ready         in_data  : data_byte, last_byte
// output   out_valid / out_ready       out_data : code, end_of_stream
//
// a byte that extends the current string with a first-probe hit passes through the steps
// accept, hash, table read and compare; each extra probe of the hashed table repeats the
// table read and compare, limited by the single read port of the pair table; a miss adds an emit step
// reset and the end of every stream start a clearing pass over all TABLE_ENTRIES entries,
// one table entry per cycle, during which no byte is accepted
// a waiting result sits in the output register; a new byte is taken meanwhile and
// the block only stalls when it must emit while that register is still full
// TABLE_ENTRIES must be a power of two
module lzw_byte_compressor #(
  parameter int unsigned CODE_BITS = 16,
  parameter int unsigned TABLE_ENTRIES = 131072
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lzwc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lzwc_pkg::out_t out_data
);

  // command and status between controller and datapath
  lzwc_pkg::cmd_t cmd;
  lzwc_pkg::sts_t sts;

  lzwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  lzwc_dp #(
    .CODE_BITS     (CODE_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
